// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the timestamp ratio converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk, off while rst_n is low
`define TRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define TRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/trc_pkg.sv =====
// Package: widths, codes and bundle types of the timestamp ratio converter.
`timescale 1ns / 1ps

package trc_pkg;

    localparam int VALUE_W    = 64;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = VALUE_W + COEF_W;
    localparam int DIV_STAGES = VALUE_W;
    localparam int BUF_DEPTH  = 2;
    localparam int CNT_W      = $clog2(BUF_DEPTH + 1);

    // Fixed divisor of the nanoseconds mode
    localparam logic [COEF_W-1:0] NS_PER_SEC = 32'd1000000000;

    // Register indexes of the write port
    typedef enum logic [1:0] {
        REG_OFFSET  = 2'd0,
        REG_DENOM   = 2'd1,
        REG_NUMER   = 2'd2,
        REG_CRYSTAL = 2'd3
    } cfg_idx_t;

    // Request modes
    typedef enum logic {
        MODE_TIMESTAMP = 1'b0,
        MODE_NANOSEC   = 1'b1
    } req_mode_t;

    typedef struct packed {
        logic [VALUE_W-1:0] offset;
        logic [COEF_W-1:0]  denom;
        logic [COEF_W-1:0]  numer;
        logic [COEF_W-1:0]  crystal;
    } cfg_t;

    // One divider stage: partial remainder, dividend/quotient shifter, divisor, saturation flag
    typedef struct packed {
        logic [COEF_W-1:0]  rem;
        logic [VALUE_W-1:0] shreg;
        logic [COEF_W-1:0]  dvsr;
        logic               sat;
    } div_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               sat;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } buf_stat_t;

endpackage

// ===== hw/rtl/trc_req_if.sv =====
// Interface: request channel (mode and input value).
`timescale 1ns / 1ps

interface trc_req_if;
    import trc_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [VALUE_W-1:0] value_in;

    modport source (output valid, req_type, value_in, input ready);
    modport sink   (input valid, req_type, value_in, output ready);
endinterface

// ===== hw/rtl/trc_rsp_if.sv =====
// Interface: response channel (converted value and saturation flag).
`timescale 1ns / 1ps

interface trc_rsp_if;
    import trc_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] result_value;
    logic               saturated;

    modport source (output valid, result_value, saturated, input ready);
    modport sink   (input valid, result_value, saturated, output ready);
endinterface

// ===== hw/rtl/trc_cfg.sv =====
// Configuration register file with a plain write port.
`timescale 1ns / 1ps

module trc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  trc_pkg::cfg_idx_t              cfg_index,
    input  logic [trc_pkg::VALUE_W-1:0]    cfg_data,
    output trc_pkg::cfg_t                  cfg
);
    import trc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; wider data is cut to the register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OFFSET:  cfg_next.offset  = cfg_data;
                REG_DENOM:   cfg_next.denom   = cfg_data[COEF_W-1:0];
                REG_NUMER:   cfg_next.numer   = cfg_data[COEF_W-1:0];
                REG_CRYSTAL: cfg_next.crystal = cfg_data[COEF_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset  <= '0;
            cfg_reg.denom   <= COEF_W'(1);
            cfg_reg.numer   <= COEF_W'(1);
            cfg_reg.crystal <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/trc_front.sv =====
// Front end: offset and operand select, split 64x32 multiply, product sum.
`timescale 1ns / 1ps

module trc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          req_type,
    input  logic [trc_pkg::VALUE_W-1:0]   value_in,
    input  trc_pkg::cfg_t                 cfg,
    output logic                          out_valid,
    output trc_pkg::div_t                 out_data
);
    import trc_pkg::*;

    localparam int HALF_W = VALUE_W / 2;

    // Stage A: operands
    logic                a_valid_reg;
    logic [VALUE_W-1:0]  a_val_reg;
    logic [COEF_W-1:0]   a_mul_reg;
    logic [COEF_W-1:0]   a_dvsr_reg;
    logic [VALUE_W-1:0]  a_val_next;
    logic [COEF_W-1:0]   a_mul_next;
    logic [COEF_W-1:0]   a_dvsr_next;

    // Stage B: partial products
    logic                      b_valid_reg;
    logic [HALF_W+COEF_W-1:0]  b_plo_reg;
    logic [HALF_W+COEF_W-1:0]  b_phi_reg;
    logic [COEF_W-1:0]         b_dvsr_reg;

    // Stage C: full product
    logic                c_valid_reg;
    logic [PROD_W-1:0]   c_prod_reg;
    logic [PROD_W-1:0]   c_prod_next;
    logic [COEF_W-1:0]   c_dvsr_reg;

    // Mode select: timestamp minus offset wraps modulo 2^64
    always_comb
    begin
        if (req_mode_t'(req_type) == MODE_NANOSEC)
        begin
            a_val_next  = value_in;
            a_mul_next  = cfg.crystal;
            a_dvsr_next = NS_PER_SEC;
        end
        else
        begin
            a_val_next  = value_in - cfg.offset;
            a_mul_next  = cfg.denom;
            a_dvsr_next = cfg.numer;
        end
    end

    // Upper partial product shifted up by one half word
    assign c_prod_next = {b_phi_reg, {HALF_W{1'b0}}}
                       + {{(PROD_W-HALF_W-COEF_W){1'b0}}, b_plo_reg};

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_val_reg  <= a_val_next;
            a_mul_reg  <= a_mul_next;
            a_dvsr_reg <= a_dvsr_next;
            b_plo_reg  <= {{COEF_W{1'b0}}, a_val_reg[HALF_W-1:0]}
                        * {{HALF_W{1'b0}}, a_mul_reg};
            b_phi_reg  <= {{COEF_W{1'b0}}, a_val_reg[VALUE_W-1:HALF_W]}
                        * {{HALF_W{1'b0}}, a_mul_reg};
            b_dvsr_reg <= a_dvsr_reg;
            c_prod_reg <= c_prod_next;
            c_dvsr_reg <= b_dvsr_reg;
        end
    end

    // Product upper 32 bits feed the divider as its starting remainder
    assign out_valid      = c_valid_reg;
    assign out_data.rem   = c_prod_reg[PROD_W-1:VALUE_W];
    assign out_data.shreg = c_prod_reg[VALUE_W-1:0];
    assign out_data.dvsr  = c_dvsr_reg;

    // Quotient overflows when the product upper 32 bits reach the divisor
    assign out_data.sat   = (c_prod_reg[PROD_W-1:VALUE_W] >= c_dvsr_reg);

endmodule

// ===== hw/rtl/trc_div_stage.sv =====
// One restoring-division stage: yields one quotient bit per beat.
`timescale 1ns / 1ps

module trc_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  trc_pkg::div_t   in_data,
    output logic            out_valid,
    output trc_pkg::div_t   out_data
);
    import trc_pkg::*;

    logic                valid_reg;
    div_t                data_reg;
    div_t                data_next;
    logic [COEF_W:0]     shifted;
    logic [COEF_W:0]     diff;
    logic                ge;

    // Shift in the next dividend bit, subtract when it fits
    assign shifted = {in_data.rem, in_data.shreg[VALUE_W-1]};
    assign ge      = shifted >= {1'b0, in_data.dvsr};
    assign diff    = shifted - {1'b0, in_data.dvsr};

    always_comb
    begin
        data_next       = in_data;
        data_next.rem   = ge ? diff[COEF_W-1:0] : shifted[COEF_W-1:0];
        data_next.shreg = {in_data.shreg[VALUE_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/trc_outbuf.sv =====
// Two-entry output buffer that decouples the pipeline from the response side.
`timescale 1ns / 1ps

module trc_outbuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  trc_pkg::res_t         push_data,
    trc_rsp_if.source             rsp,
    output trc_pkg::buf_stat_t    stat
);
    import trc_pkg::*;

    localparam int PTR_W = $clog2(BUF_DEPTH);

    res_t               mem_reg [BUF_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    assign pop = rsp.valid && rsp.ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Head entry drives the response beat
    assign rsp.valid        = (count_reg != '0);
    assign rsp.result_value = mem_reg[rd_ptr_reg].value;
    assign rsp.saturated    = mem_reg[rd_ptr_reg].sat;

    assign stat.full  = (count_reg == CNT_W'(BUF_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== hw/rtl/timestamp_ratio_converter.sv =====
// Top level: 64-bit multiply-then-divide timestamp converter with saturation.
//
//  Channel   Dir   Beat contents
//  req       in    req_type, value_in
//  rsp       out   result_value, saturated
//  cfg_*     in    write enable, register index, 64-bit data
//
// One beat per cycle sustained while the output buffer has room.
// The pipeline has 3 front stages (select, partial products, sum) and 64
// one-bit divider stages, followed by a two-entry output buffer.
// The whole pipeline advances while the buffer has room; a full buffer stalls
// it and drops req.ready until a beat leaves. Reset clears valid bits and buffer
// pointers and sets the settings to defaults; data registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module timestamp_ratio_converter (
    input  logic                         clk,
    input  logic                         rst_n,
    trc_req_if.sink                      req,
    trc_rsp_if.source                    rsp,
    input  logic                         cfg_we,
    input  trc_pkg::cfg_idx_t            cfg_index,
    input  logic [trc_pkg::VALUE_W-1:0]  cfg_data
);
    import trc_pkg::*;

    cfg_t               cfg;
    logic               adv;
    buf_stat_t          buf_stat;
    logic               front_valid;
    div_t               front_data;
    logic [DIV_STAGES:0] div_v;
    div_t               div_d [DIV_STAGES+1];
    res_t               res;

    trc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline moves whenever the output buffer is not full
    assign adv       = !buf_stat.full;
    assign req.ready = adv;

    trc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (req.valid),
        .req_type  (req.req_type),
        .value_in  (req.value_in),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    // Divider chain input
    assign div_v[0] = front_valid;
    assign div_d[0] = front_data;

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        trc_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (div_v[i]),
            .in_data   (div_d[i]),
            .out_valid (div_v[i+1]),
            .out_data  (div_d[i+1])
        );
    end

    // Saturated results read as all ones
    assign res.value = div_d[DIV_STAGES].sat ? {VALUE_W{1'b1}} : div_d[DIV_STAGES].shreg;
    assign res.sat   = div_d[DIV_STAGES].sat;

    trc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (div_v[DIV_STAGES] && adv),
        .push_data (res),
        .rsp       (rsp),
        .stat      (buf_stat)
    );

    // Checks
    `TRC_ASSERT(a_sat_all_ones, !(rsp.valid && rsp.saturated) || (rsp.result_value == '1), "saturated beat not all ones")
    `TRC_ASSERT_NEXT(a_tail_held, !adv && div_v[DIV_STAGES], div_v[DIV_STAGES], "stalled result lost")
    `TRC_ASSERT_NEXT(a_push_lands, adv && div_v[DIV_STAGES], !buf_stat.empty, "pushed result missing")
    `TRC_ASSERT(a_empty_quiet, !buf_stat.empty || !rsp.valid, "response valid with empty buffer")

endmodule
